// ===== hw/rtl/srta_pkg.sv =====
// ----------------------------------------------------------------------------
// srta_pkg
// Shared constants, types and helper functions of the signed radix to ASCII
// converter.
// ----------------------------------------------------------------------------
package srta_pkg;

    localparam int VALUE_W     = 64;
    localparam int MAG_W       = VALUE_W - 1;
    localparam int CHAR_W      = 8;
    localparam int RADIX_W     = 5;
    localparam int DIGIT_W     = 4;
    localparam int CFG_W       = 64;
    localparam int REG_INDEX_W = 2;
    localparam int MAX_RADIX   = 16;
    localparam int MAX_DIGITS  = 64;
    localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);
    localparam int COUNT_W     = DIGIT_IDX_W + 1;
    localparam int DIV_BITS    = 8;
    localparam int DIV_STEPS   = VALUE_W / DIV_BITS;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    localparam logic [RADIX_W-1:0] RADIX_RESET      = 5'd10;
    localparam logic [CFG_W-1:0]   CHARS_LOW_RESET  = 64'h3736_3534_3332_3130;
    localparam logic [CFG_W-1:0]   CHARS_HIGH_RESET = 64'h4645_4443_4241_3938;
    localparam logic [CHAR_W-1:0]  MINUS_CHAR       = 8'h2D;
    localparam logic [MAG_W-1:0]   MAG_LIMIT        = {MAG_W{1'b1}};
    localparam logic [VALUE_W-1:0] VALUE_MOST_NEG   = {1'b1, {MAG_W{1'b0}}};

    typedef enum logic [REG_INDEX_W-1:0] {
        REG_RADIX      = 2'd0,
        REG_CHARS_LOW  = 2'd1,
        REG_CHARS_HIGH = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SIGN,
        ST_READ,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic emit_init;
        logic emit_read;
        logic load_sign;
        logic load_digit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_done;
        logic negative;
        logic out_free;
        logic emit_one;
    } dp_status_t;

    // clamp the programmed radix into 2 .. MAX_RADIX
    function automatic logic [RADIX_W-1:0] effective_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_W'(2))
            res = RADIX_W'(2);
        else if (r > RADIX_W'(MAX_RADIX))
            res = RADIX_W'(MAX_RADIX);
        return res;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [CFG_W-1:0] chars_low,
                                                     input logic [CFG_W-1:0] chars_high,
                                                     input logic [DIGIT_W-1:0] d);
        logic [CFG_W-1:0] word;
        logic [CFG_W-1:0] shifted;
        word    = d[3] ? chars_high : chars_low;
        shifted = word >> {d[2:0], 3'b000};
        return shifted[CHAR_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/srta_ifs.sv =====
// ----------------------------------------------------------------------------
// srta stream interfaces
// Valid/ready channels for the input value and the output characters.
// ----------------------------------------------------------------------------
interface srta_value_if;
    logic                                valid;
    logic                                ready;
    logic signed [srta_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface srta_text_if;
    logic                         valid;
    logic                         ready;
    logic [srta_pkg::CHAR_W-1:0]  character;
    logic                         last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== hw/rtl/srta_ctrl.sv =====
// ----------------------------------------------------------------------------
// srta_ctrl
// Sequencer: accept, divide digit by digit, sign, then replay digits.
// ----------------------------------------------------------------------------
module srta_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  srta_pkg::dp_status_t   status,
    output srta_pkg::ctrl_cmd_t    cmd
);

    srta_pkg::state_t state_reg;
    srta_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= srta_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            srta_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = srta_pkg::ST_DIVIDE;
            end
            srta_pkg::ST_DIVIDE:
            begin
                if (status.div_done)
                    state_next = srta_pkg::ST_SIGN;
            end
            srta_pkg::ST_SIGN:
            begin
                if (!status.negative || status.out_free)
                    state_next = srta_pkg::ST_READ;
            end
            srta_pkg::ST_READ:
            begin
                state_next = srta_pkg::ST_WRITE;
            end
            srta_pkg::ST_WRITE:
            begin
                if (status.out_free)
                    state_next = status.emit_one ? srta_pkg::ST_IDLE : srta_pkg::ST_READ;
            end
            default:
            begin
                state_next = srta_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            srta_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            srta_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            srta_pkg::ST_SIGN:
            begin
                cmd.emit_init = 1'b1;
                cmd.load_sign = status.negative && status.out_free;
            end
            srta_pkg::ST_READ:
            begin
                cmd.emit_read = 1'b1;
            end
            srta_pkg::ST_WRITE:
            begin
                cmd.load_digit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/srta_dpath.sv =====
// ----------------------------------------------------------------------------
// srta_dpath
// Configuration registers, 8-bit-per-cycle divider, digit memory and
// output character register.
// ----------------------------------------------------------------------------
module srta_dpath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  srta_pkg::ctrl_cmd_t                  cmd,
    output srta_pkg::dp_status_t                 status,
    input  logic signed [srta_pkg::VALUE_W-1:0]  value,
    input  logic                                 write_enable,
    input  logic [srta_pkg::REG_INDEX_W-1:0]     reg_index,
    input  logic [srta_pkg::CFG_W-1:0]           write_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [srta_pkg::CHAR_W-1:0]          out_character,
    output logic                                 out_last
);

    logic [srta_pkg::RADIX_W-1:0]     radix_reg;
    logic [srta_pkg::CFG_W-1:0]       chars_low_reg;
    logic [srta_pkg::CFG_W-1:0]       chars_high_reg;
    logic [srta_pkg::RADIX_W-1:0]     radix_eff;

    logic [srta_pkg::VALUE_W-1:0]     dividend_reg;
    logic [srta_pkg::DIGIT_W-1:0]     rem_reg;
    logic [srta_pkg::STEP_W-1:0]      step_cnt_reg;
    logic [srta_pkg::COUNT_W-1:0]     digit_count_reg;
    logic                             negative_reg;
    logic [srta_pkg::COUNT_W-1:0]     emit_idx_reg;
    logic [srta_pkg::DIGIT_W-1:0]     rd_data_reg;
    logic                             out_valid_reg;
    logic [srta_pkg::CHAR_W-1:0]      out_char_reg;
    logic                             out_last_reg;

    logic [srta_pkg::DIGIT_W-1:0]     digit_mem [srta_pkg::MAX_DIGITS];

    logic                             value_neg;
    logic [srta_pkg::VALUE_W-1:0]     value_negated;
    logic [srta_pkg::MAG_W-1:0]       magnitude;
    logic [srta_pkg::DIGIT_W:0]       trial;
    logic [srta_pkg::DIGIT_W-1:0]     rem_next;
    logic [srta_pkg::DIV_BITS-1:0]    qbits;
    logic [srta_pkg::VALUE_W-1:0]     quot_next;
    logic                             step_last;
    logic [srta_pkg::COUNT_W-1:0]     emit_dec;
    logic [srta_pkg::DIGIT_IDX_W-1:0] rd_addr;
    logic                             out_valid_next;

    assign radix_eff = srta_pkg::effective_radix(radix_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg      <= srta_pkg::RADIX_RESET;
            chars_low_reg  <= srta_pkg::CHARS_LOW_RESET;
            chars_high_reg <= srta_pkg::CHARS_HIGH_RESET;
        end
        else if (write_enable)
        begin
            unique case (reg_index)
                srta_pkg::REG_RADIX:      radix_reg      <= write_data[srta_pkg::RADIX_W-1:0];
                srta_pkg::REG_CHARS_LOW:  chars_low_reg  <= write_data;
                srta_pkg::REG_CHARS_HIGH: chars_high_reg <= write_data;
                default:                  ;
            endcase
        end
    end

    // sign and magnitude, most negative value saturates
    assign value_neg     = value[srta_pkg::VALUE_W-1];
    assign value_negated = ~value + srta_pkg::VALUE_W'(1);
    always_comb
    begin
        if (!value_neg)
            magnitude = value[srta_pkg::MAG_W-1:0];
        else if (value == srta_pkg::VALUE_MOST_NEG)
            magnitude = srta_pkg::MAG_LIMIT;
        else
            magnitude = value_negated[srta_pkg::MAG_W-1:0];
    end

    // restoring division, eight dividend bits per cycle
    always_comb
    begin
        rem_next = rem_reg;
        qbits    = '0;
        trial    = '0;
        for (int i = 0; i < srta_pkg::DIV_BITS; i++)
        begin
            trial = {rem_next, dividend_reg[srta_pkg::VALUE_W-1-i]};
            if (trial >= radix_eff)
            begin
                rem_next = srta_pkg::DIGIT_W'(trial - radix_eff);
                qbits[srta_pkg::DIV_BITS-1-i] = 1'b1;
            end
            else
            begin
                rem_next = trial[srta_pkg::DIGIT_W-1:0];
            end
        end
    end

    assign quot_next = {dividend_reg[srta_pkg::VALUE_W-srta_pkg::DIV_BITS-1:0], qbits};
    assign step_last = (step_cnt_reg == srta_pkg::STEP_W'(srta_pkg::DIV_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dividend_reg    <= '0;
            rem_reg         <= '0;
            step_cnt_reg    <= '0;
            digit_count_reg <= '0;
            negative_reg    <= 1'b0;
        end
        else if (cmd.load)
        begin
            dividend_reg    <= {1'b0, magnitude};
            rem_reg         <= '0;
            step_cnt_reg    <= '0;
            digit_count_reg <= '0;
            negative_reg    <= value_neg;
        end
        else if (cmd.div_step)
        begin
            step_cnt_reg <= step_cnt_reg + srta_pkg::STEP_W'(1);
            if (step_last)
            begin
                // quotient stays in place as the next dividend
                dividend_reg    <= quot_next;
                rem_reg         <= '0;
                digit_count_reg <= digit_count_reg + srta_pkg::COUNT_W'(1);
            end
            else
            begin
                dividend_reg <= quot_next;
                rem_reg      <= rem_next;
            end
        end
    end

    assign emit_dec = emit_idx_reg - srta_pkg::COUNT_W'(1);
    assign rd_addr  = emit_dec[srta_pkg::DIGIT_IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.div_step && step_last)
            digit_mem[digit_count_reg[srta_pkg::DIGIT_IDX_W-1:0]] <= rem_next;
        if (cmd.emit_read)
            rd_data_reg <= digit_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            emit_idx_reg <= '0;
        else if (cmd.emit_init)
            emit_idx_reg <= digit_count_reg;
        else if (cmd.load_digit)
            emit_idx_reg <= emit_dec;
    end

    always_comb
    begin
        if (cmd.load_sign || cmd.load_digit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_sign)
        begin
            out_char_reg <= srta_pkg::MINUS_CHAR;
            out_last_reg <= 1'b0;
        end
        else if (cmd.load_digit)
        begin
            out_char_reg <= srta_pkg::digit_char(chars_low_reg, chars_high_reg, rd_data_reg);
            out_last_reg <= (emit_idx_reg == srta_pkg::COUNT_W'(1));
        end
    end

    assign status.div_done = step_last && ((quot_next == '0) ||
                             (digit_count_reg == srta_pkg::COUNT_W'(srta_pkg::MAX_DIGITS - 1)));
    assign status.negative = negative_reg;
    assign status.out_free = !out_valid_reg || out_ready;
    assign status.emit_one = (emit_idx_reg == srta_pkg::COUNT_W'(1));

    assign out_valid     = out_valid_reg;
    assign out_character = out_char_reg;
    assign out_last      = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        digit_count_reg <= srta_pkg::COUNT_W'(srta_pkg::MAX_DIGITS))
        else $error("digit count beyond store depth");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, rem_reg} < radix_eff)
        else $error("partial remainder not below radix");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_read |-> (emit_idx_reg != '0))
        else $error("digit read with no digit left");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_digit || cmd.load_sign) |-> (!out_valid_reg || out_ready))
        else $error("output word overwritten before it was taken");

endmodule

// ===== hw/rtl/signed_radix_to_ascii_core.sv =====
// ----------------------------------------------------------------------------
// signed_radix_to_ascii_core
// Converts a signed 64-bit value to ASCII text in a programmable radix,
// one character word per output handshake, most significant first.
// ----------------------------------------------------------------------------
// order: accept, divide digit by digit (8 dividend bits a cycle), then the sign,
//   then per digit a memory read and a load that waits for a free output register
// the next value is accepted once the last character sits in the output register
// reset: radix 10, table "0123456789ABCDEF", no output word pending
module signed_radix_to_ascii_core (
    input  logic                                clk,
    input  logic                                rst_n,
    srta_value_if.sink                          operand,
    srta_text_if.source                         text,
    input  logic                                write_enable,
    input  logic [srta_pkg::REG_INDEX_W-1:0]    reg_index,
    input  logic [srta_pkg::CFG_W-1:0]          write_data
);

    srta_pkg::ctrl_cmd_t  cmd;
    srta_pkg::dp_status_t status;

    srta_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (operand.valid),
        .in_ready (operand.ready),
        .status   (status),
        .cmd      (cmd)
    );

    srta_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .value         (operand.value),
        .write_enable  (write_enable),
        .reg_index     (reg_index),
        .write_data    (write_data),
        .out_valid     (text.valid),
        .out_ready     (text.ready),
        .out_character (text.character),
        .out_last      (text.last)
    );

endmodule
